>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks that report by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a consequent holds whenever an antecedent holds
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

>>> src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Types and constants shared by the mecanum stepper step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int WHEELS           = 4;
  localparam int MODE_BITS        = 4;
  localparam int SPEED_BITS       = 12;
  localparam int ERR_BITS         = 16;
  localparam int MIX_BITS         = 18;
  localparam int MAG_BITS         = 12;
  localparam int HP_BITS          = 9;
  localparam int RECIP_BITS       = 13;
  localparam int RECIP_SHIFT      = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int DEF_COUNTER_BITS = 16;

  localparam logic signed [MIX_BITS-1:0] OFS_HENG1 = MIX_BITS'(240);
  localparam logic signed [MIX_BITS-1:0] OFS_HENG2 = MIX_BITS'(300);
  localparam logic [MIX_BITS-1:0]        EN_LIMIT  = MIX_BITS'(10);
  // 400 * 10: above this the half-period saturates at its minimum
  localparam logic [MIX_BITS-1:0]        MAG_CLAMP = MIX_BITS'(4000);
  localparam logic [HP_BITS-1:0]         HP_BASE   = HP_BITS'(410);
  // round-up reciprocal of 10 in 16 fractional bits
  localparam logic [RECIP_BITS-1:0]      RECIP_10  = RECIP_BITS'(6554);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK   = 4'd0,
    MODE_STOP   = 4'd1,
    MODE_FWD_R  = 4'd2,
    MODE_FWD_L  = 4'd3,
    MODE_MID_Q  = 4'd4,
    MODE_MID_H  = 4'd5,
    MODE_STABLE = 4'd6,
    MODE_MODIFY = 4'd7,
    MODE_HENG   = 4'd8,
    MODE_HENG1  = 4'd9,
    MODE_HENG2  = 4'd10,
    MODE_TURN   = 4'd11
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_APPLY = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                           kind;
    logic [WHEELS-1:0]               en;
    logic [WHEELS-1:0]               dir;
    logic [WHEELS-1:0][HP_BITS-1:0]  hp;
  } op_t;

endpackage

`default_nettype wire

>>> src/mss_if.sv
// ----------------------------------------------------------------------------
// mss channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [mss_pkg::MODE_BITS-1:0]       mode;
  logic signed [mss_pkg::ERR_BITS-1:0] err_gyro;
  logic signed [mss_pkg::ERR_BITS-1:0] err_second;
  logic signed [mss_pkg::ERR_BITS-1:0] err_third;

  modport source (output valid, mode, err_gyro, err_second, err_third, input ready);
  modport sink   (input valid, mode, err_gyro, err_second, err_third, output ready);
endinterface

interface mss_res_if;
  logic                              valid;
  logic                              ready;
  logic [mss_pkg::WHEELS-1:0]        step_mask;
  logic [mss_pkg::WHEELS-1:0]        enable_mask;
  logic [mss_pkg::WHEELS-1:0]        direction_mask;
  logic [mss_pkg::HP_BITS-1:0]       period_left_front;
  logic [mss_pkg::HP_BITS-1:0]       period_left_rear;
  logic [mss_pkg::HP_BITS-1:0]       period_right_front;
  logic [mss_pkg::HP_BITS-1:0]       period_right_rear;

  modport source (output valid, step_mask, enable_mask, direction_mask, period_left_front,
                  period_left_rear, period_right_front, period_right_rear, input ready);
  modport sink   (input valid, step_mask, enable_mask, direction_mask, period_left_front,
                  period_left_rear, period_right_front, period_right_rear, output ready);
endinterface

`default_nettype wire

>>> src/mecanum_stepper_step_generator.sv
// ----------------------------------------------------------------------------
// mecanum_stepper_step_generator
// Mecanum wheel speed mixing and stepper pulse generation for four wheels.
// ----------------------------------------------------------------------------
// channel   dir  handshake    payload
// cmd_i     in   valid/ready  mode, err_gyro, err_second, err_third
// res_o     out  valid/ready  step/enable/direction masks, four half-periods
// cfg       in   cfg_we_i     cfg_wdata_i -> set_speed
//
// One item per cycle sustained while results are taken; after its item is accepted a result
// passes pipeline stages two and three, the queue write and the result register.
// Reset clears the counter, all wheel state, set_speed and every valid flag.
// A stalled result holds the engine; the four-entry queue lets the pipeline
// keep accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_stepper_step_generator #(
  parameter int COUNTER_BITS = mss_pkg::DEF_COUNTER_BITS
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [mss_pkg::SPEED_BITS-1:0]  cfg_wdata_i,
  mss_cmd_if.sink                        cmd_i,
  mss_res_if.source                      res_o
);
  import mss_pkg::*;

  logic [SPEED_BITS-1:0] set_speed_q;
  logic                  push_valid, push_ready, pop_valid, pop_ready;
  op_t                   push_op, pop_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_speed_q <= '0;
    end else if (cfg_we_i) begin
      set_speed_q <= cfg_wdata_i;
    end
  end

  mss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .set_speed_i  (set_speed_q),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  mss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  mss_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (pop_valid),
    .op_ready_o (pop_ready),
    .op_i       (pop_op),
    .res_o      (res_o)
  );

`include "assert_macros.svh"

  `ASSERT_IMPL(a_lf_en_period, res_o.valid,
               res_o.enable_mask[0] == (res_o.period_left_front != '0),
               "left front enable and half-period disagree")
  `ASSERT_IMPL(a_rr_en_period, res_o.valid,
               res_o.enable_mask[3] == (res_o.period_right_rear != '0),
               "right rear enable and half-period disagree")
  `ASSERT_IMPL(a_pop_only_valid, pop_ready && !pop_valid,
               !(push_valid && !push_ready),
               "queue stalls the pipeline while empty")

endmodule

`default_nettype wire

>>> src/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front
// Three-stage command pipeline: mix wheel speeds, take magnitudes, derive
// enables, directions and half-periods, then push one operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire [mss_pkg::SPEED_BITS-1:0]    set_speed_i,
  mss_cmd_if.sink                          cmd_i,
  output logic                             push_valid_o,
  input  wire                              push_ready_i,
  output mss_pkg::op_t                     push_op_o
);
  import mss_pkg::*;

  logic ld1, ld2, ld3;

  logic                                     s1_valid_q;
  kind_e                                    s1_kind_q, s1_kind_d;
  logic signed [WHEELS-1:0][MIX_BITS-1:0]   s1_w_q, s1_w_d;

  logic                                     s2_valid_q;
  kind_e                                    s2_kind_q;
  logic [WHEELS-1:0]                        s2_en_q, s2_en_d;
  logic [WHEELS-1:0]                        s2_dir_q, s2_dir_d;
  logic [WHEELS-1:0][MAG_BITS-1:0]          s2_mag_q, s2_mag_d;

  logic                                     s3_valid_q;
  op_t                                      s3_op_q, s3_op_d;

  logic signed [MIX_BITS-1:0] s, e1, e2, e3;
  logic [WHEELS-1:0][MIX_BITS-1:0]                  abs_w;
  logic [WHEELS-1:0][MAG_BITS+RECIP_BITS-1:0]       prod;

  assign ld3 = !s3_valid_q || push_ready_i;
  assign ld2 = !s2_valid_q || ld3;
  assign ld1 = !s1_valid_q || ld2;
  assign cmd_i.ready = ld1;

  assign push_valid_o = s3_valid_q;
  assign push_op_o    = s3_op_q;

  always_comb begin
    s  = {{(MIX_BITS-SPEED_BITS){1'b0}}, set_speed_i};
    e1 = {{(MIX_BITS-ERR_BITS){cmd_i.err_gyro[ERR_BITS-1]}}, cmd_i.err_gyro};
    e2 = {{(MIX_BITS-ERR_BITS){cmd_i.err_second[ERR_BITS-1]}}, cmd_i.err_second};
    e3 = {{(MIX_BITS-ERR_BITS){cmd_i.err_third[ERR_BITS-1]}}, cmd_i.err_third};
    s1_w_d    = '0;
    s1_kind_d = KIND_APPLY;
    case (mode_e'(cmd_i.mode))
      MODE_TICK:   s1_kind_d = KIND_TICK;
      MODE_STOP:   s1_w_d = '0;
      MODE_FWD_R: begin
        s1_w_d[0] = s - e1 - e2; s1_w_d[1] = s - e1 + e2;
        s1_w_d[2] = s + e1 + e2; s1_w_d[3] = s + e1 - e2;
      end
      MODE_FWD_L: begin
        s1_w_d[0] = s - e1 + e2; s1_w_d[1] = s - e1 - e2;
        s1_w_d[2] = s + e1 - e2; s1_w_d[3] = s + e1 + e2;
      end
      MODE_MID_Q: begin
        s1_w_d[0] = s - e1 + e2 - e3; s1_w_d[1] = s - e1 - e2 - e3;
        s1_w_d[2] = s + e1 - e2 + e3; s1_w_d[3] = s + e1 + e2 + e3;
      end
      MODE_MID_H: begin
        s1_w_d[0] = -s - e1 + e2 - e3; s1_w_d[1] = -s - e1 - e2 - e3;
        s1_w_d[2] = -s + e1 - e2 + e3; s1_w_d[3] = -s + e1 + e2 + e3;
      end
      MODE_STABLE: begin
        s1_w_d[0] = s - e1 - e2; s1_w_d[1] = s - e1 - e2;
        s1_w_d[2] = s + e1 - e2; s1_w_d[3] = s + e1 - e2;
      end
      MODE_MODIFY: begin
        s1_w_d[0] = -e1 + e2 + e3; s1_w_d[1] = -e1 - e2 + e3;
        s1_w_d[2] = e1 - e2 + e3;  s1_w_d[3] = e1 + e2 + e3;
      end
      MODE_HENG: begin
        s1_w_d[0] = s - e1 - e2;  s1_w_d[1] = -s - e1 - e2;
        s1_w_d[2] = -s + e1 - e2; s1_w_d[3] = s + e1 - e2;
      end
      MODE_HENG1: begin
        s1_w_d[0] = s + OFS_HENG1 - e1 - e2; s1_w_d[1] = -s - e1 - e2;
        s1_w_d[2] = -s + e1 - e2;            s1_w_d[3] = s + OFS_HENG1 + e1 - e2;
      end
      MODE_HENG2: begin
        s1_w_d[0] = s + OFS_HENG2 - e1 - e2; s1_w_d[1] = -s - e1 - e2;
        s1_w_d[2] = -s + e1 - e2;            s1_w_d[3] = s + OFS_HENG2 + e1 - e2;
      end
      MODE_TURN: begin
        s1_w_d[0] = -e1; s1_w_d[1] = -e1;
        s1_w_d[2] = e1;  s1_w_d[3] = e1;
      end
      default:     s1_kind_d = KIND_NONE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      abs_w[i]    = s1_w_q[i][MIX_BITS-1] ? (~s1_w_q[i] + 1'b1) : s1_w_q[i];
      s2_en_d[i]  = abs_w[i] > EN_LIMIT;
      s2_dir_d[i] = (i >= WHEELS / 2) ? !s1_w_q[i][MIX_BITS-1] : s1_w_q[i][MIX_BITS-1];
      s2_mag_d[i] = (abs_w[i] >= MAG_CLAMP) ? MAG_CLAMP[MAG_BITS-1:0]
                                            : abs_w[i][MAG_BITS-1:0];
    end
  end

  always_comb begin
    s3_op_d.kind = s2_kind_q;
    s3_op_d.en   = s2_en_q;
    s3_op_d.dir  = s2_dir_q;
    for (int i = 0; i < WHEELS; i++) begin
      prod[i] = {{RECIP_BITS{1'b0}}, s2_mag_q[i]} * {{MAG_BITS{1'b0}}, RECIP_10};
      s3_op_d.hp[i] = s2_en_q[i] ? (HP_BASE - prod[i][RECIP_SHIFT +: HP_BITS]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (ld1) s1_valid_q <= cmd_i.valid;
      if (ld2) s2_valid_q <= s1_valid_q;
      if (ld3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_kind_q <= s1_kind_d;
      s1_w_q    <= s1_w_d;
    end
    if (ld2) begin
      s2_kind_q <= s1_kind_q;
      s2_en_q   <= s2_en_d;
      s2_dir_q  <= s2_dir_d;
      s2_mag_q  <= s2_mag_d;
    end
    if (ld3) begin
      s3_op_q <= s3_op_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mss_queue.sv
// ----------------------------------------------------------------------------
// mss_queue
// Short FIFO of decoded operations between the command pipeline and the
// step engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  wire mss_pkg::op_t    push_op_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output mss_pkg::op_t         pop_op_o
);
  import mss_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  op_t                 entry_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = count_q != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_op_i;
  end

endmodule

`default_nettype wire

>>> src/mss_back.sv
// ----------------------------------------------------------------------------
// mss_back
// Step engine: holds the counter and wheel state, carries out tick and
// wheel-update operations, and registers one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back #(
  parameter int COUNTER_BITS = mss_pkg::DEF_COUNTER_BITS
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  op_valid_i,
  output logic                 op_ready_o,
  input  wire mss_pkg::op_t    op_i,
  mss_res_if.source            res_o
);
  import mss_pkg::*;

  logic [COUNTER_BITS-1:0]               cnt_q, cnt_d;
  logic [WHEELS-1:0][COUNTER_BITS-1:0]   cmp_q, cmp_d;
  logic [WHEELS-1:0][HP_BITS-1:0]        hp_q, hp_d;
  logic [WHEELS-1:0]                     lvl_q, lvl_d;
  logic [WHEELS-1:0]                     en_q, en_d;
  logic [WHEELS-1:0]                     dir_q, dir_d;
  logic                                  res_valid_q;
  logic [WHEELS-1:0]                     step_q, enm_q, dirm_q;
  logic [WHEELS-1:0][HP_BITS-1:0]        per_q;
  logic                                  fire;

  assign op_ready_o = !res_valid_q || res_o.ready;
  assign fire       = op_valid_i && op_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    cmp_d = cmp_q;
    hp_d  = hp_q;
    lvl_d = lvl_q;
    en_d  = en_q;
    dir_d = dir_q;
    if (fire) begin
      case (op_i.kind)
        KIND_TICK: begin
          cnt_d = cnt_q + 1'b1;
          for (int i = 0; i < WHEELS; i++) begin
            if (en_q[i] && cmp_q[i] == cnt_d) begin
              lvl_d[i] = !lvl_q[i];
              cmp_d[i] = cnt_d + {{(COUNTER_BITS-HP_BITS){1'b0}}, hp_q[i]};
            end
          end
        end
        KIND_APPLY: begin
          en_d = op_i.en;
          hp_d = op_i.hp;
          for (int i = 0; i < WHEELS; i++) begin
            if (op_i.en[i]) dir_d[i] = op_i.dir[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_q       <= '0;
      hp_q        <= '0;
      lvl_q       <= '0;
      en_q        <= '0;
      dir_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cmp_q <= cmp_d;
      hp_q  <= hp_d;
      lvl_q <= lvl_d;
      en_q  <= en_d;
      dir_q <= dir_d;
      if (op_ready_o) res_valid_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      step_q <= lvl_d;
      enm_q  <= en_d;
      dirm_q <= dir_d;
      per_q  <= hp_d;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.step_mask          = step_q;
  assign res_o.enable_mask        = enm_q;
  assign res_o.direction_mask     = dirm_q;
  assign res_o.period_left_front  = per_q[0];
  assign res_o.period_left_rear   = per_q[1];
  assign res_o.period_right_front = per_q[2];
  assign res_o.period_right_rear  = per_q[3];

endmodule

`default_nettype wire

>>> test/mecanum_stepper_step_generator_tb.sv
// ----------------------------------------------------------------------------
// mecanum_stepper_step_generator_tb
// Drives mixing commands and timer ticks into the step generator and keeps
// its own copy of the wheel state. Each result item is compared field by
// field with the state expected after the matching command. The run covers
// several base speeds and a stretch of ticks with the wheels enabled. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module mecanum_stepper_step_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int CNT_BITS          = DEF_COUNTER_BITS;
  localparam int DEADBAND          = 10;
  localparam int SPEED_PER_COUNT   = 10;
  localparam int MAG_CAP           = 400;
  localparam int HP_TOP            = 410;
  localparam int HENG1_BOOST       = 240;
  localparam int HENG2_BOOST       = 300;
  localparam int SPEED_MAX         = 4000;
  localparam int FIRST_UNUSED_MODE = MODE_TURN + 1;
  localparam int LAST_MODE         = 2**MODE_BITS - 1;
  localparam int RESET_CYCLES      = 11;
  localparam int DRAIN_TAIL        = 8;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int LONG_HOLD_CYCLES  = 150;
  localparam int MAX_REPORTS       = 10;
  localparam int TICK_RUN          = 200;
  localparam int RANDOM_ITEMS      = 1050;
  localparam int SPEED_PHASES      = 6;

  localparam logic signed [ERR_BITS-1:0] ERR_MAX = 16'sh7FFF;
  localparam logic signed [ERR_BITS-1:0] ERR_MIN = 16'sh8000;

  typedef struct {
    logic [WHEELS-1:0]  step_mask;
    logic [WHEELS-1:0]  enable_mask;
    logic [WHEELS-1:0]  direction_mask;
    logic [HP_BITS-1:0] period [WHEELS];
  } wheel_report_t;

  class wheel_state_tracker;
    logic [SPEED_BITS-1:0] set_speed;
    logic [CNT_BITS-1:0]   tick_count;
    logic [CNT_BITS-1:0]   compare_val [WHEELS];
    logic [HP_BITS-1:0]    half_period [WHEELS];
    logic [WHEELS-1:0]     step_lvl;
    logic [WHEELS-1:0]     wheel_en;
    logic [WHEELS-1:0]     wheel_dir;
    wheel_report_t         expected_states [$];
    int                    failures;

    function new();
      set_speed  = '0;
      tick_count = '0;
      step_lvl   = '0;
      wheel_en   = '0;
      wheel_dir  = '0;
      foreach (compare_val[i]) begin
        compare_val[i] = '0;
        half_period[i] = '0;
      end
      failures = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void set_wheel(int w, int speed);
      int mag;
      if (speed > DEADBAND || speed < -DEADBAND) begin
        mag = (speed < 0 ? -speed : speed) / SPEED_PER_COUNT;
        if (mag > MAG_CAP) mag = MAG_CAP;
        wheel_en[w]    = 1'b1;
        half_period[w] = HP_BITS'(HP_TOP - mag);
        // right side pins are inverted
        wheel_dir[w]   = (w >= 2) ? (speed > 0) : (speed < 0);
      end else begin
        wheel_en[w]    = 1'b0;
        half_period[w] = '0;
      end
    endfunction

    function void note_command(logic [MODE_BITS-1:0] mode, logic signed [ERR_BITS-1:0] e_gyro,
                               logic signed [ERR_BITS-1:0] e_side,
                               logic signed [ERR_BITS-1:0] e_mid);
      int            s, g, b, c;
      int            spd [WHEELS];
      bit            mixes;
      wheel_report_t rep;
      s = int'(set_speed);
      g = e_gyro;
      b = e_side;
      c = e_mid;
      mixes = 1'b1;
      foreach (spd[i]) spd[i] = 0;
      case (mode)
        MODE_TICK: begin
          mixes = 1'b0;
          tick_count = tick_count + 1'b1;
          for (int i = 0; i < WHEELS; i++) begin
            if (wheel_en[i] && compare_val[i] == tick_count) begin
              step_lvl[i]    = ~step_lvl[i];
              compare_val[i] = tick_count + CNT_BITS'(half_period[i]);
            end
          end
        end
        MODE_STOP: ;
        MODE_FWD_R: begin
          spd[0] = s - g - b; spd[1] = s - g + b; spd[2] = s + g + b; spd[3] = s + g - b;
        end
        MODE_FWD_L: begin
          spd[0] = s - g + b; spd[1] = s - g - b; spd[2] = s + g - b; spd[3] = s + g + b;
        end
        MODE_MID_Q: begin
          spd[0] = s - g + b - c; spd[1] = s - g - b - c;
          spd[2] = s + g - b + c; spd[3] = s + g + b + c;
        end
        MODE_MID_H: begin
          spd[0] = -s - g + b - c; spd[1] = -s - g - b - c;
          spd[2] = -s + g - b + c; spd[3] = -s + g + b + c;
        end
        MODE_STABLE: begin
          spd[0] = s - g - b; spd[1] = s - g - b; spd[2] = s + g - b; spd[3] = s + g - b;
        end
        MODE_MODIFY: begin
          spd[0] = -g + b + c; spd[1] = -g - b + c; spd[2] = g - b + c; spd[3] = g + b + c;
        end
        MODE_HENG: begin
          spd[0] = s - g - b; spd[1] = -s - g - b; spd[2] = -s + g - b; spd[3] = s + g - b;
        end
        MODE_HENG1: begin
          spd[0] = s + HENG1_BOOST - g - b; spd[1] = -s - g - b;
          spd[2] = -s + g - b;              spd[3] = s + HENG1_BOOST + g - b;
        end
        MODE_HENG2: begin
          spd[0] = s + HENG2_BOOST - g - b; spd[1] = -s - g - b;
          spd[2] = -s + g - b;              spd[3] = s + HENG2_BOOST + g - b;
        end
        MODE_TURN: begin
          spd[0] = -g; spd[1] = -g; spd[2] = g; spd[3] = g;
        end
        default: mixes = 1'b0;
      endcase
      if (mixes) foreach (spd[i]) set_wheel(i, spd[i]);
      rep.step_mask      = step_lvl;
      rep.enable_mask    = wheel_en;
      rep.direction_mask = wheel_dir;
      foreach (rep.period[i]) rep.period[i] = half_period[i];
      expected_states.push_back(rep);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) flag($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    function void check_state(wheel_report_t got);
      wheel_report_t want;
      if (expected_states.size() == 0) begin
        flag("result item with no command pending");
      end else begin
        want = expected_states.pop_front();
        compare_field("step_mask", want.step_mask, got.step_mask);
        compare_field("enable_mask", want.enable_mask, got.enable_mask);
        compare_field("direction_mask", want.direction_mask, got.direction_mask);
        compare_field("period_left_front", want.period[0], got.period[0]);
        compare_field("period_left_rear", want.period[1], got.period[1]);
        compare_field("period_right_front", want.period[2], got.period[2]);
        compare_field("period_right_rear", want.period[3], got.period[3]);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [SPEED_BITS-1:0] cfg_wdata_i;

  mss_cmd_if cmd_ch ();
  mss_res_if res_ch ();

  wheel_state_tracker tracker = new();

  int idle_cycles    = 0;
  int long_hold_req  = 0;
  int long_hold_done = 0;
  int sender_burst   = 0;
  int sender_max_gap = 8;

  mecanum_stepper_step_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : result_monitor
    wheel_report_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.step_mask      = res_ch.step_mask;
      got.enable_mask    = res_ch.enable_mask;
      got.direction_mask = res_ch.direction_mask;
      got.period[0]      = res_ch.period_left_front;
      got.period[1]      = res_ch.period_left_rear;
      got.period[2]      = res_ch.period_right_front;
      got.period[3]      = res_ch.period_right_rear;
      tracker.check_state(got);
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : result_sink
    int style, left, hold_left, phase;
    style = 0;
    left = 0;
    hold_left = 0;
    phase = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_hold_req != long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = long_hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        phase++;
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 9) < 7);
          2: res_ch.ready <= (phase % 5 != 0);
          default: res_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic pace();
    int gap;
    if (sender_burst > 0) begin
      sender_burst--;
    end else begin
      sender_burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, sender_max_gap);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_item(input logic [MODE_BITS-1:0] mode,
                           input logic signed [ERR_BITS-1:0] e_gyro,
                           input logic signed [ERR_BITS-1:0] e_side,
                           input logic signed [ERR_BITS-1:0] e_mid);
    pace();
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= mode;
    cmd_ch.err_gyro   <= e_gyro;
    cmd_ch.err_second <= e_side;
    cmd_ch.err_third  <= e_mid;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    tracker.note_command(mode, e_gyro, e_side, e_mid);
    @(negedge clk_i);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (tracker.expected_states.size() != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.set_speed = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [ERR_BITS-1:0] pick_err(int spread);
    int v;
    case (spread)
      0: v = int'($urandom_range(0, 65535));
      1: v = int'($urandom_range(0, 1200)) - 600;
      2: v = int'($urandom_range(0, 40)) - 20;
      default: begin
        case ($urandom_range(0, 2))
          0: v = ERR_MAX;
          1: v = ERR_MIN;
          default: v = 0;
        endcase
      end
    endcase
    return ERR_BITS'(v);
  endfunction

  task automatic send_mix(output bit counted);
    logic [MODE_BITS-1:0] mode;
    int                   r;
    r = $urandom_range(0, 99);
    if (r < 45) mode = MODE_TICK;
    else if (r < 49) mode = MODE_BITS'($urandom_range(FIRST_UNUSED_MODE, LAST_MODE));
    else mode = MODE_BITS'($urandom_range(MODE_STOP, MODE_TURN));
    send_item(mode, pick_err($urandom_range(0, 3)), pick_err($urandom_range(0, 3)),
              pick_err($urandom_range(0, 3)));
    counted = (mode <= MODE_TURN);
  endtask

  initial begin : stimulus
    int ticks_left, next_cmd, sent;
    bit counted;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_TICK;
    cmd_ch.err_gyro   = '0;
    cmd_ch.err_second = '0;
    cmd_ch.err_third  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // base speed at its reset value: thresholds, saturation, ignored modes
    send_item(MODE_TICK, ERR_MAX, ERR_MIN, ERR_MAX);
    send_item(MODE_BITS'(LAST_MODE), ERR_MIN, ERR_MAX, ERR_MIN);
    send_item(MODE_TURN, 16'sd11, 16'sd0, 16'sd0);
    send_item(MODE_TURN, -16'sd10, 16'sd0, 16'sd0);
    send_item(MODE_BITS'(FIRST_UNUSED_MODE), 16'sd500, 16'sd0, 16'sd0);
    send_item(MODE_TURN, -16'sd11, 16'sd0, 16'sd0);
    send_item(MODE_TURN, 16'sd10, 16'sd0, 16'sd0);
    send_item(MODE_TURN, 16'sd3999, 16'sd0, 16'sd0);
    send_item(MODE_TURN, 16'sd4000, 16'sd0, 16'sd0);
    send_item(MODE_TURN, -16'sd4010, 16'sd0, 16'sd0);
    send_item(MODE_TURN, ERR_MAX, ERR_MIN, ERR_MAX);
    send_item(MODE_TURN, ERR_MIN, ERR_MAX, ERR_MIN);
    send_item(MODE_STOP, ERR_MAX, ERR_MAX, ERR_MAX);
    drain();
    write_speed(SPEED_BITS'(SPEED_MAX));
    send_item(MODE_FWD_R, ERR_MIN, ERR_MAX, 16'sd0);
    send_item(MODE_FWD_L, ERR_MAX, ERR_MAX, 16'sd0);
    send_item(MODE_MID_Q, ERR_MIN, ERR_MAX, ERR_MIN);
    send_item(MODE_MID_H, ERR_MAX, ERR_MAX, ERR_MAX);
    send_item(MODE_STABLE, 16'sd0, 16'sd0, 16'sd0);
    send_item(MODE_MODIFY, ERR_MIN, ERR_MIN, ERR_MIN);
    send_item(MODE_HENG, 16'sd5, 16'sd5, 16'sd0);
    send_item(MODE_HENG1, 16'sd0, 16'sd0, 16'sd0);
    send_item(MODE_HENG2, 16'sd0, 16'sd0, 16'sd0);
    drain();
    write_speed('0);
    send_item(MODE_HENG1, 16'sd0, 16'sd0, 16'sd0);
    send_item(MODE_HENG2, 16'sd0, 16'sd0, 16'sd0);
    send_item(MODE_MODIFY, 16'sd0, 16'sd0, 16'sd0);
    drain();

    // run a stretch of ticks with the wheels enabled, commands mixed in
    write_speed(SPEED_BITS'($urandom_range(1000, SPEED_MAX)));
    sender_max_gap = 3;
    send_item(MODE_FWD_R, pick_err(1), pick_err(1), pick_err(1));
    long_hold_req++;
    ticks_left = TICK_RUN;
    next_cmd = $urandom_range(20, 60);
    while (ticks_left > 0) begin
      if (next_cmd == 0) begin
        send_item(MODE_BITS'($urandom_range(MODE_FWD_R, MODE_TURN)), pick_err(1), pick_err(1),
                  pick_err(1));
        next_cmd = $urandom_range(20, 60);
      end else begin
        send_item(MODE_TICK, pick_err(0), pick_err(0), pick_err(0));
        ticks_left--;
        next_cmd--;
      end
    end

    sender_max_gap = 8;
    for (int ph = 0; ph < SPEED_PHASES; ph++) begin
      drain();
      if (ph == 0) write_speed(SPEED_BITS'(SPEED_MAX));
      else if (ph == 1) write_speed('0);
      else write_speed(SPEED_BITS'($urandom_range(0, SPEED_MAX)));
      if (ph == 2) long_hold_req++;
      sent = 0;
      while (sent < RANDOM_ITEMS / SPEED_PHASES) begin
        send_mix(counted);
        if (counted) sent++;
      end
    end
    drain();

    if (tracker.expected_states.size() != 0) tracker.flag("results still pending at end");
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
